[design/mkd_pkg.sv]
// Shared types and constants for the debounced 4x4 matrix keypad scanner.
// No dependencies; imported by mkd_encode and matrix_keypad_debounce.
`default_nettype none

package mkd_pkg;

	// ASCII key code, zero means no key
	typedef logic [6:0] code_t;

	// column levels of one driven row, active low
	typedef logic [3:0] cols_t;

	localparam int    ROWS           = 4;
	localparam int    COLS           = 4;
	localparam code_t NO_KEY         = 7'h00;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd15;

	// keymap, row by row, column 0 first
	localparam code_t KEYMAP [0:ROWS-1][0:COLS-1] = '{
		'{7'h31, 7'h32, 7'h33, 7'h41},  // 1 2 3 A
		'{7'h34, 7'h35, 7'h36, 7'h42},  // 4 5 6 B
		'{7'h37, 7'h38, 7'h39, 7'h43},  // 7 8 9 C
		'{7'h2A, 7'h30, 7'h23, 7'h44}   // * 0 # D
	};

endpackage

`default_nettype wire

[design/matrix_keypad_debounce.sv]
// Top level of the debounced 4x4 matrix keypad scanner.
// Depends on mkd_pkg and mkd_encode.
`default_nettype none

// One request is one complete keypad scan with its millisecond timestamp, and
// every request yields exactly one result (key_valid, key_code). A request is
// taken in every cycle that in_stall is low: it lands in an input register,
// the key code is encoded and the debounce state updated in one pass, and the
// result sits in an output register, so throughput is one scan per cycle while
// no stall holds. A stall on the result side holds both registers and
// back-pressures the input through in_stall. A raw key code must stay
// unchanged for at least debounce_ms milliseconds (elapsed time taken modulo
// 2^TIME_BITS) before it becomes the stable key; each new nonzero stable key
// is reported once. Write debounce_ms only while no scan is in flight.
module matrix_keypad_debounce
	import mkd_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	// scan requests
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [3:0]  row0_columns,
	input  wire  [3:0]  row1_columns,
	input  wire  [3:0]  row2_columns,
	input  wire  [3:0]  row3_columns,
	input  wire  [31:0] now_ms,
	// results
	output logic        out_valid,
	input  wire         out_stall,
	output logic        key_valid,
	output logic [6:0]  key_code
);

	localparam int EXT_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int CMP_BITS = (TIME_BITS > 16) ? TIME_BITS : 16;

	typedef logic [TIME_BITS-1:0] stamp_t;

	logic [15:0]   debounce_q;
	code_t         cand_q;
	code_t         stable_q;
	logic          reported_q;
	stamp_t        start_q;

	logic          valid_s1;
	cols_t         row0_s1, row1_s1, row2_s1, row3_s1;
	stamp_t        now_s1;

	logic          valid_s2;
	logic          key_valid_s2;
	code_t         key_code_s2;

	logic [EXT_BITS-1:0] now_ext;
	code_t         raw_code;
	logic          advance;
	logic          take_s1;
	logic          cand_chg;
	stamp_t        start_n;
	stamp_t        elapsed;
	logic          settle;
	code_t         stable_n;
	logic          rep_base;
	logic          report;

	// keep only the low TIME_BITS bits of the timestamp
	assign now_ext = EXT_BITS'(now_ms);

	// move stage 1 on unless the result register is held
	assign advance  = !(valid_s2 && out_stall);
	assign take_s1  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_wr_en) begin
			debounce_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			row0_s1 <= row0_columns;
			row1_s1 <= row1_columns;
			row2_s1 <= row2_columns;
			row3_s1 <= row3_columns;
			now_s1  <= now_ext[TIME_BITS-1:0];
		end
	end

	mkd_encode u_encode (
		.row0_columns (row0_s1),
		.row1_columns (row1_s1),
		.row2_columns (row2_s1),
		.row3_columns (row3_s1),
		.raw_code     (raw_code)
	);

	// restart the timer on a new candidate, then promote it once settled
	always_comb begin
		cand_chg = (raw_code != cand_q);
		start_n  = cand_chg ? now_s1 : start_q;
		elapsed  = now_s1 - start_n;
		settle   = (CMP_BITS'(elapsed) >= CMP_BITS'(debounce_q)) && (raw_code != stable_q);
		stable_n = settle ? raw_code : stable_q;
		rep_base = settle ? 1'b0 : reported_q;
		report   = (stable_n != NO_KEY) && !rep_base;
	end

	// debounce state, updated as each scan passes to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q     <= NO_KEY;
			stable_q   <= NO_KEY;
			reported_q <= 1'b0;
			start_q    <= '0;
		end else if (take_s1) begin
			cand_q     <= raw_code;
			stable_q   <= stable_n;
			reported_q <= rep_base || report;
			start_q    <= start_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			key_valid_s2 <= report;
			key_code_s2  <= report ? stable_n : NO_KEY;
		end
	end

	assign out_valid = valid_s2;
	assign key_valid = key_valid_s2;
	assign key_code  = key_code_s2;

	// a reported key is never the empty code
	a_report_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && key_valid_s2) |-> (key_code_s2 != NO_KEY))
		else $error("reported key code is zero");

	// a result without a report carries no code
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !key_valid_s2) |-> (key_code_s2 == NO_KEY))
		else $error("key code set without report");

	// a report marks the stable key as reported
	a_mark_reported: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && report) |=> reported_q)
		else $error("report did not set reported flag");

	// a new candidate restarts its timer at the scan timestamp
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && cand_chg) |=> (start_q == $past(now_s1)))
		else $error("candidate timer not restarted");

	// input is held back only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without cause");

endmodule

`default_nettype wire

[design/mkd_encode.sv]
// Priority encoder and keymap lookup for one complete 4x4 scan.
// Depends on mkd_pkg for the keymap and code type.
`default_nettype none

module mkd_encode
	import mkd_pkg::*;
(
	input  wire cols_t row0_columns,
	input  wire cols_t row1_columns,
	input  wire cols_t row2_columns,
	input  wire cols_t row3_columns,
	output code_t      raw_code
);

	cols_t rows [0:ROWS-1];

	assign rows[0] = row0_columns;
	assign rows[1] = row1_columns;
	assign rows[2] = row2_columns;
	assign rows[3] = row3_columns;

	// scan from lowest priority up so the lowest row and column win
	always_comb begin
		raw_code = NO_KEY;
		for (int r = ROWS - 1; r >= 0; r--) begin
			for (int c = COLS - 1; c >= 0; c--) begin
				if (!rows[r][c]) begin
					raw_code = KEYMAP[r][c];
				end
			end
		end
	end

endmodule

`default_nettype wire

[tb/keypad_report_checker.sv]
// Checker for the debounced keypad scanner: watches the scan and result channels.
// Predicts one report per accepted scan and compares it in order. Needs mkd_pkg.
`timescale 1ns / 1ps

module keypad_report_checker
	import mkd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [3:0]  row0_columns,
	input  wire  [3:0]  row1_columns,
	input  wire  [3:0]  row2_columns,
	input  wire  [3:0]  row3_columns,
	input  wire  [31:0] now_ms,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire         key_valid,
	input  wire  [6:0]  key_code,
	output int          mismatch_count,
	output int          reports_due
);

	typedef struct packed {
		logic  hit;
		code_t code;
	} report_t;

	// key legend in scan order: row 0 first, column 0 first within a row
	localparam logic [127:0] KEY_LAYOUT = "123A456B789C*0#D";

	logic [15:0] settle_ms       = DEBOUNCE_RESET;
	code_t       candidate       = NO_KEY;
	code_t       accepted_key    = NO_KEY;
	logic        announced       = 1'b0;
	logic [31:0] candidate_since = '0;
	report_t     expected_reports [$];
	report_t     want;

	initial begin
		mismatch_count = 0;
		reports_due    = 0;
	end

	// first closed contact in priority order, mapped to its ASCII code
	function automatic code_t first_closed(logic [15:0] contacts);
		for (int i = 0; i < 16; i++) begin
			if (!contacts[i])
				return KEY_LAYOUT[8*(15-i) +: 7];
		end
		return NO_KEY;
	endfunction

	// advance the debounce state by one scan and queue the report it causes
	task automatic predict_report(logic [15:0] contacts, logic [31:0] stamp);
		code_t       raw;
		logic [31:0] held_ms;
		report_t     rep;
		raw = first_closed(contacts);
		if (raw != candidate) begin
			candidate       = raw;
			candidate_since = stamp;
		end
		held_ms = stamp - candidate_since;
		if (held_ms >= {16'd0, settle_ms} && candidate != accepted_key) begin
			accepted_key = candidate;
			announced    = 1'b0;
		end
		if (accepted_key != NO_KEY && !announced) begin
			announced = 1'b1;
			rep.hit   = 1'b1;
			rep.code  = accepted_key;
		end else begin
			rep.hit  = 1'b0;
			rep.code = NO_KEY;
		end
		expected_reports.push_back(rep);
	endtask

	task automatic log_mismatch(string why, report_t exp_rep);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns %s: expected key_valid=%0b key_code=%h, got key_valid=%0b key_code=%h",
				$time, why, exp_rep.hit, exp_rep.code, key_valid, key_code);
	endtask

	// compare results in order, then record any config write and new scan
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ms       = DEBOUNCE_RESET;
			candidate       = NO_KEY;
			accepted_key    = NO_KEY;
			announced       = 1'b0;
			candidate_since = '0;
			expected_reports.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					want = '0;
					log_mismatch("result with no scan pending", want);
				end else begin
					want = expected_reports.pop_front();
					if (key_valid !== want.hit || key_code !== want.code)
						log_mismatch("wrong report", want);
				end
			end
			if (cfg_wr_en)
				settle_ms = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_report({row3_columns, row2_columns, row1_columns, row0_columns}, now_ms);
		end
		reports_due = expected_reports.size();
	end

endmodule

[tb/matrix_keypad_debounce_tb.sv]
// Testbench top for matrix_keypad_debounce: drives scans, result stalls and config.
// Depends on mkd_pkg, the block and keypad_report_checker.
`timescale 1ns / 1ps

module matrix_keypad_debounce_tb;
	import mkd_pkg::*;

	localparam int SCANS_PER_PHASE = 250;
	localparam int PHASES          = 7;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int SETTLE_CYCLES   = 4;
	localparam logic [15:0] ALL_OPEN = 16'hFFFF;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_wr_en    = 1'b0;
	logic [15:0] cfg_wr_data  = '0;
	logic        in_valid     = 1'b0;
	cols_t       row0_columns = '1;
	cols_t       row1_columns = '1;
	cols_t       row2_columns = '1;
	cols_t       row3_columns = '1;
	logic [31:0] now_ms       = '0;
	logic        out_stall    = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire         key_valid;
	wire  [6:0]  key_code;
	int          mismatch_count;
	int          reports_due;

	logic        steady      = 1'b0;
	logic        hold_phase  = 1'b0;
	logic [31:0] scan_ms     = '0;
	int          scans_offered = 0;
	logic [15:0] settle_plan [PHASES];

	always #5 clk = ~clk;

	matrix_keypad_debounce u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row0_columns (row0_columns),
		.row1_columns (row1_columns),
		.row2_columns (row2_columns),
		.row3_columns (row3_columns),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_valid    (key_valid),
		.key_code     (key_code)
	);

	keypad_report_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.row0_columns   (row0_columns),
		.row1_columns   (row1_columns),
		.row2_columns   (row2_columns),
		.row3_columns   (row3_columns),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_valid      (key_valid),
		.key_code       (key_code),
		.mismatch_count (mismatch_count),
		.reports_due    (reports_due)
	);

	// hard stop in case the block hangs
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	// result side: random stalls, one long hold-off during the hold phase
	initial begin
		int  phase_cycles;
		bit  held;
		phase_cycles = 0;
		held         = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_phase && !held)
				phase_cycles++;
			if (hold_phase && !held && phase_cycles == 50) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				held = 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(0, 99) < 11);
			end
		end
	end

	// offer one scan, packed as {row3, row2, row1, row0}, and hold it until taken
	task automatic offer_scan(logic [15:0] contacts, logic [31:0] stamp);
		if (!steady && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		row0_columns <= contacts[3:0];
		row1_columns <= contacts[7:4];
		row2_columns <= contacts[11:8];
		row3_columns <= contacts[15:12];
		now_ms       <= stamp;
		in_valid     <= 1'b1;
		scans_offered++;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and wait until every scan has produced its report
	task automatic drain_requests();
		in_valid <= 1'b0;
		do @(negedge clk); while (reports_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settle(logic [15:0] value);
		drain_requests();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// one closed contact, optionally crowded by lower-priority contacts
	function automatic logic [15:0] press_contacts(int key, bit crowd);
		logic [15:0] contacts;
		contacts      = ALL_OPEN;
		contacts[key] = 1'b0;
		if (crowd) begin
			for (int i = key + 1; i < 16; i++) begin
				if ($urandom_range(0, 3) == 0)
					contacts[i] = 1'b0;
			end
		end
		return contacts;
	endfunction

	// press, hold and release one key, with contact bounce on both ends
	task automatic key_stroke(logic [15:0] settle);
		int key;
		key = $urandom_range(0, 15);
		repeat ($urandom_range(0, 3)) begin
			scan_ms += $urandom_range(0, settle / 4 + 1);
			offer_scan($urandom_range(0, 1) ? press_contacts(key, 1'b1) : ALL_OPEN, scan_ms);
		end
		repeat ($urandom_range(2, 7)) begin
			scan_ms += $urandom_range(0, settle / 2 + 2);
			offer_scan(press_contacts(key, $urandom_range(0, 3) == 0), scan_ms);
		end
		repeat ($urandom_range(0, 2)) begin
			scan_ms += $urandom_range(0, settle / 4 + 1);
			offer_scan($urandom_range(0, 1) ? press_contacts(key, 1'b0) : ALL_OPEN, scan_ms);
		end
		repeat ($urandom_range(1, 5)) begin
			scan_ms += $urandom_range(0, settle / 2 + 2);
			offer_scan(ALL_OPEN, scan_ms);
		end
	endtask

	// garbage scan, sometimes with a timestamp jump anywhere in the range
	task automatic line_noise();
		if ($urandom_range(0, 3) == 0)
			scan_ms = $urandom();
		else
			scan_ms += $urandom_range(0, 8);
		offer_scan(16'($urandom()), scan_ms);
	endtask

	initial begin
		int target;
		settle_plan = '{16'd15, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd7, 16'd0};
		settle_plan[4] = 16'($urandom_range(2, 60));
		settle_plan[6] = 16'($urandom());

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed scans at the reset debounce time
		offer_scan(ALL_OPEN, 32'd0);
		offer_scan(16'h0000, 32'hFFFF_FFFF);   // all keys down, start just before wrap
		offer_scan(16'h0000, 32'd14);          // held across the wrap
		offer_scan(ALL_OPEN, 32'd20);
		offer_scan(ALL_OPEN, 32'd40);          // release goes quiet
		offer_scan(16'h7FFF, 32'd50);          // D, last in priority
		offer_scan(16'h7FFF, 32'd60);          // not held long enough yet
		offer_scan(16'h7FFF, 32'd65);
		offer_scan(16'h0AFF, 32'd70);          // 7 beats the whole bottom row
		offer_scan(16'h0AFF, 32'd200);
		offer_scan(ALL_OPEN, 32'd210);
		offer_scan(ALL_OPEN, 32'd230);
		offer_scan(16'h0AFF, 32'd240);         // same key again after release
		offer_scan(16'h0AFF, 32'd300);
		offer_scan(16'hFFDF, 32'hFFFF_FFF0);
		offer_scan(16'hFFDF, 32'h0000_0010);
		offer_scan(16'hBFFF, 32'd1000);
		offer_scan(16'hBFFF, 32'd500);         // backwards jump reads as a long hold
		offer_scan(16'hEFFF, 32'h8000_0000);
		offer_scan(16'hFFF0, 32'h8000_0000);
		offer_scan(16'hFFF0, 32'h8000_0040);
		offer_scan(ALL_OPEN, 32'hFFFF_FFFF);
		scan_ms = 32'hFFFF_FFFF;

		// random phases, one debounce setting each
		for (int phase = 0; phase < PHASES; phase++) begin
			write_settle(settle_plan[phase]);
			steady     <= (phase == 5);
			hold_phase <= (phase == 3);
			target = scans_offered + SCANS_PER_PHASE;
			while (scans_offered < target) begin
				if ($urandom_range(0, 9) == 0)
					line_noise();
				else
					key_stroke(settle_plan[phase]);
			end
		end

		drain_requests();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
design/mkd_pkg.sv
design/mkd_encode.sv
design/matrix_keypad_debounce.sv
tb/keypad_report_checker.sv
tb/matrix_keypad_debounce_tb.sv
